>>> rtl/core/gifl_pkg.sv
// Package for the GPIO interrupt flood limiter: table size, op and register codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package gifl_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_OUT_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] OP_ATTACH = 2'd0;
    localparam logic [1:0] OP_EVENT  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] MODE_NONE = 2'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_QUOTA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY = 1'd1;

    localparam logic [15:0] QUOTA_RESET = 16'd10000;
    localparam logic [7:0]  RETRY_RESET = 8'd100;
    localparam logic [7:0]  WAIT_MAX    = 8'hFF;

    typedef struct packed {
        logic              capture;
        logic              scan;
        logic              load_row;
        logic              load_sum;
        logic [SLOT_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic row_valid;
        logic out_free;
    } dp_sts_t;

endpackage

>>> rtl/core/gpio_irq_flood_limiter_core.sv
// GPIO interrupt flood limiter: top level joining sequencer and datapath.
// Depends on gifl_pkg, gifl_ctrl and gifl_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item: attach/detach, an
//   interrupt event or a tick. Each item yields one or more output beats on
//   out_valid/out_ready; the final beat of an item has last set.
//   Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
//   ready and should only be issued while no item is in flight.
// Sequence:
//   An accepted item walks the slot table once to update it, then walks it
//   again to send per-slot beats, then sends the summary beat. A new item is
//   taken only once the sequencer is back in idle after the summary beat has
//   been loaded.
// Reset: all slots free, quota 10000, retry wait 100, no beat pending.
// Stall: a held output beat stops the emit walk at the next slot with a row
//   to send; the next item can be accepted while the last summary beat still waits in the output register.
module gpio_irq_flood_limiter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          op,
    input  logic [7:0]                          pin,
    input  logic [1:0]                          edge_mode,
    input  logic                                level,
    input  logic [31:0]                         time_us,
    input  logic                                armed,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gifl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gifl_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [gifl_pkg::SLOT_OUT_W-1:0]     slot,
    output logic [7:0]                          pin_out,
    output logic                                level_out,
    output logic [31:0]                         time_out,
    output logic                                delivered,
    output logic                                flood_report,
    output logic                                armed_flood,
    output logic                                retried,
    output logic                                ok,
    output logic                                flood_blocked,
    output logic                                last
);
    import gifl_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    gifl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    gifl_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .op             (op),
        .pin            (pin),
        .edge_mode      (edge_mode),
        .level          (level),
        .time_us        (time_us),
        .armed          (armed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slot           (slot),
        .pin_out        (pin_out),
        .level_out      (level_out),
        .time_out       (time_out),
        .delivered      (delivered),
        .flood_report   (flood_report),
        .armed_flood    (armed_flood),
        .retried        (retried),
        .ok             (ok),
        .flood_blocked  (flood_blocked),
        .last           (last)
    );

endmodule

>>> rtl/core/gifl_ctrl.sv
// Sequencer for the flood limiter: capture, slot scan, row emit, summary row.
// Depends on gifl_pkg.
module gifl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output gifl_pkg::dp_cmd_t cmd,
    input  gifl_pkg::dp_sts_t sts
);
    import gifl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_SUM
    } state_t;

    state_t            state_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              idx_last;
    logic              emit_adv;

    assign idx_last = (idx_reg == SLOT_W'(SLOTS - 1));
    // a row slot moves on when it has nothing to send or its beat is loaded
    assign emit_adv = !sts.row_valid || sts.out_free;

    always_comb
    begin
        cmd.capture  = (state_reg == ST_IDLE) && in_valid;
        cmd.scan     = (state_reg == ST_SCAN);
        cmd.load_row = (state_reg == ST_EMIT) && sts.row_valid && sts.out_free;
        cmd.load_sum = (state_reg == ST_SUM) && sts.out_free;
        cmd.idx      = idx_reg;
        in_ready     = (state_reg == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_SCAN;
                        idx_reg   <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (idx_last)
                    begin
                        state_reg <= ST_EMIT;
                        idx_reg   <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_adv)
                    begin
                        if (idx_last)
                        begin
                            state_reg <= ST_SUM;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_SUM:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_capture_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_SCAN) && (idx_reg == '0))
        else $error("capture did not start a scan at slot zero");

    a_row_load_gated: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_row |-> (sts.row_valid && sts.out_free && !cmd.load_sum))
        else $error("row loaded without a pending row or a free output");

    a_sum_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_sum |=> (state_reg == ST_IDLE))
        else $error("summary beat did not return the sequencer to idle");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan || cmd.load_row) |-> !in_ready)
        else $error("input ready while an item is in progress");

endmodule

>>> rtl/core/gifl_dp.sv
// Datapath of the flood limiter: slot table, per-slot row flags, config
// registers and the output register. Depends on gifl_pkg.
module gifl_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gifl_pkg::dp_cmd_t                   cmd,
    output gifl_pkg::dp_sts_t                   sts,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gifl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gifl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                          op,
    input  logic [7:0]                          pin,
    input  logic [1:0]                          edge_mode,
    input  logic                                level,
    input  logic [31:0]                         time_us,
    input  logic                                armed,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [gifl_pkg::SLOT_OUT_W-1:0]     slot,
    output logic [7:0]                          pin_out,
    output logic                                level_out,
    output logic [31:0]                         time_out,
    output logic                                delivered,
    output logic                                flood_report,
    output logic                                armed_flood,
    output logic                                retried,
    output logic                                ok,
    output logic                                flood_blocked,
    output logic                                last
);
    import gifl_pkg::*;

    // config
    logic [15:0] quota_cfg_reg;
    logic [7:0]  retry_cfg_reg;

    // captured input item
    logic [1:0]  op_reg;
    logic [7:0]  pin_reg;
    logic [1:0]  mode_reg;
    logic        level_reg;
    logic [31:0] time_reg;
    logic        armed_reg;

    // slot table
    logic        used_reg  [SLOTS];
    logic [7:0]  spin_reg  [SLOTS];
    logic [15:0] quota_reg [SLOTS];
    logic [7:0]  wait_reg  [SLOTS];

    // row flags left by the scan
    logic        rv_reg    [SLOTS];
    logic        dv_reg    [SLOTS];
    logic        fl_reg    [SLOTS];
    logic        ie_reg    [SLOTS];
    logic        rt_reg    [SLOTS];

    logic              found_reg;
    logic [SLOT_W-1:0] found_slot_reg;
    logic              blk_reg;

    logic        out_valid_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic [7:0]  pin_out_reg;
    logic        level_out_reg;
    logic [31:0] time_out_reg;
    logic        deliv_out_reg;
    logic        flood_out_reg;
    logic        ierr_out_reg;
    logic        retry_out_reg;
    logic        ok_out_reg;
    logic        blk_out_reg;
    logic        last_out_reg;

    // scan step for the slot at cmd.idx
    logic        used_c;
    logic        hit;
    logic [15:0] q_c;
    logic [7:0]  w_c;
    logic [7:0]  w_sat;
    logic        used_n;
    logic [15:0] q_n;
    logic [7:0]  w_n;
    logic        take;
    logic        rv_n;
    logic        dv_n;
    logic        fl_n;
    logic        ie_n;
    logic        rt_n;
    logic        is_attach;

    assign cfg_ready = 1'b1;
    assign is_attach = (op_reg == OP_ATTACH) && (mode_reg != MODE_NONE);

    always_comb
    begin
        used_c = used_reg[cmd.idx];
        q_c    = quota_reg[cmd.idx];
        w_c    = wait_reg[cmd.idx];
        hit    = used_c && (spin_reg[cmd.idx] == pin_reg);
        w_sat  = (w_c != WAIT_MAX) ? (w_c + 8'd1) : w_c;
        used_n = used_c;
        q_n    = q_c;
        w_n    = w_c;
        take   = 1'b0;
        rv_n   = 1'b0;
        dv_n   = 1'b0;
        fl_n   = 1'b0;
        ie_n   = 1'b0;
        rt_n   = 1'b0;
        case (op_reg)
            OP_ATTACH:
            begin
                if (mode_reg != MODE_NONE)
                begin
                    if (!used_c && !found_reg)
                    begin
                        take   = 1'b1;
                        used_n = 1'b1;
                        q_n    = quota_cfg_reg;
                        w_n    = 8'd0;
                    end
                end
                else if (hit)
                begin
                    used_n = 1'b0;
                    rv_n   = 1'b1;
                end
            end
            OP_EVENT:
            begin
                if (hit)
                begin
                    rv_n = 1'b1;
                    q_n  = (q_c != 16'd0) ? (q_c - 16'd1) : 16'd0;
                    dv_n = (q_n != 16'd0);
                end
            end
            OP_TICK:
            begin
                if (used_c)
                begin
                    if (q_c != 16'd0)
                    begin
                        q_n = quota_cfg_reg;
                    end
                    else
                    begin
                        rv_n = 1'b1;
                        fl_n = (w_c == 8'd0);
                        ie_n = (w_c == 8'd0) && armed_reg;
                        if (armed_reg)
                        begin
                            w_n = 8'd1;
                        end
                        else if (w_sat > retry_cfg_reg)
                        begin
                            q_n  = quota_cfg_reg;
                            w_n  = 8'd0;
                            rt_n = 1'b1;
                        end
                        else
                        begin
                            w_n = w_sat;
                        end
                    end
                end
            end
            default:
            begin
                rv_n = 1'b0;
            end
        endcase
    end

    assign sts.row_valid = rv_reg[cmd.idx];
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quota_cfg_reg <= QUOTA_RESET;
            retry_cfg_reg <= RETRY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_QUOTA: quota_cfg_reg <= cfg_data;
                CFG_RETRY: retry_cfg_reg <= cfg_data[7:0];
                default:   quota_cfg_reg <= quota_cfg_reg;
            endcase
        end
    end

    // control bits of the table and the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                used_reg[i] <= 1'b0;
                rv_reg[i]   <= 1'b0;
            end
            found_reg <= 1'b0;
            blk_reg   <= 1'b0;
        end
        else if (cmd.capture)
        begin
            found_reg <= 1'b0;
            blk_reg   <= 1'b0;
        end
        else if (cmd.scan)
        begin
            used_reg[cmd.idx] <= used_n;
            rv_reg[cmd.idx]   <= rv_n;
            if (take)
            begin
                found_reg <= 1'b1;
            end
            // blocked status is taken on the state this slot is left in
            blk_reg <= blk_reg || (used_n && (w_n != 8'd0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            pin_reg   <= pin;
            mode_reg  <= edge_mode;
            level_reg <= level;
            time_reg  <= time_us;
            armed_reg <= armed;
        end
        if (cmd.scan)
        begin
            quota_reg[cmd.idx] <= q_n;
            wait_reg[cmd.idx]  <= w_n;
            dv_reg[cmd.idx]    <= dv_n;
            fl_reg[cmd.idx]    <= fl_n;
            ie_reg[cmd.idx]    <= ie_n;
            rt_reg[cmd.idx]    <= rt_n;
            if (take)
            begin
                spin_reg[cmd.idx] <= pin_reg;
                found_slot_reg    <= cmd.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_row || cmd.load_sum)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            slot_reg      <= SLOT_OUT_W'(cmd.idx);
            pin_out_reg   <= spin_reg[cmd.idx];
            level_out_reg <= dv_reg[cmd.idx] && level_reg;
            time_out_reg  <= dv_reg[cmd.idx] ? time_reg : 32'd0;
            deliv_out_reg <= dv_reg[cmd.idx];
            flood_out_reg <= fl_reg[cmd.idx];
            ierr_out_reg  <= ie_reg[cmd.idx];
            retry_out_reg <= rt_reg[cmd.idx];
            // per-slot rows of op attach only come from a detach
            ok_out_reg    <= (op_reg == OP_ATTACH);
            blk_out_reg   <= blk_reg;
            last_out_reg  <= 1'b0;
        end
        else if (cmd.load_sum)
        begin
            slot_reg      <= (is_attach && found_reg) ? SLOT_OUT_W'(found_slot_reg)
                                                      : '0;
            pin_out_reg   <= (op_reg == OP_ATTACH) ? pin_reg : 8'd0;
            level_out_reg <= 1'b0;
            time_out_reg  <= 32'd0;
            deliv_out_reg <= 1'b0;
            flood_out_reg <= 1'b0;
            ierr_out_reg  <= 1'b0;
            retry_out_reg <= 1'b0;
            ok_out_reg    <= (op_reg == OP_ATTACH) && (!is_attach || found_reg);
            blk_out_reg   <= blk_reg;
            last_out_reg  <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign slot           = slot_reg;
    assign pin_out        = pin_out_reg;
    assign level_out      = level_out_reg;
    assign time_out       = time_out_reg;
    assign delivered      = deliv_out_reg;
    assign flood_report   = flood_out_reg;
    assign armed_flood    = ierr_out_reg;
    assign retried        = retry_out_reg;
    assign ok             = ok_out_reg;
    assign flood_blocked  = blk_out_reg;
    assign last           = last_out_reg;

    a_sum_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_sum |=> (out_valid_reg && last_out_reg))
        else $error("summary beat not marked last");

    a_ierr_needs_flood: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_row |=> (!ierr_out_reg || flood_out_reg))
        else $error("armed flood flag without a flood report");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(cmd.load_row || cmd.load_sum))
        else $error("output register reloaded while a beat is stalled");

endmodule

>>> sim/gifl_checker.sv
// Scoreboard for the GPIO interrupt flood limiter: watches the item, config and
// result channels, predicts result beats from its own slot table and compares them.
// Depends on gifl_pkg.
module gifl_checker
    import gifl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic [7:0]                 pin,
    input  logic [1:0]                 edge_mode,
    input  logic                       level,
    input  logic [31:0]                time_us,
    input  logic                       armed,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [SLOT_OUT_W-1:0]      slot,
    input  logic [7:0]                 pin_out,
    input  logic                       level_out,
    input  logic [31:0]                time_out,
    input  logic                       delivered,
    input  logic                       flood_report,
    input  logic                       armed_flood,
    input  logic                       retried,
    input  logic                       ok,
    input  logic                       flood_blocked,
    input  logic                       last,
    output int                         fail_count,
    output int                         rows_pending,
    output int                         rows_checked
);

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic [7:0]            pin;
        logic                  level;
        logic [31:0]           stamp;
        logic                  delivered;
        logic                  flood;
        logic                  ierr;
        logic                  retried;
        logic                  ok;
        logic                  blocked;
        logic                  last;
    } irq_row_t;

    // shadow slot table and limits
    logic        tbl_used  [SLOTS];
    logic [7:0]  tbl_pin   [SLOTS];
    logic [1:0]  tbl_mode  [SLOTS];
    logic [15:0] tbl_quota [SLOTS];
    logic [7:0]  tbl_wait  [SLOTS];
    logic [15:0] quota_lim;
    logic [7:0]  retry_lim;

    irq_row_t expected_rows [$];
    int       reported;

    function automatic string row_text(irq_row_t r);
        return $sformatf({"slot=%0d pin=%02h lvl=%0d t=%08h dlv=%0d fld=%0d ierr=%0d ",
                          "rtry=%0d ok=%0d blk=%0d last=%0d"},
                         r.slot, r.pin, r.level, r.stamp, r.delivered, r.flood, r.ierr,
                         r.retried, r.ok, r.blocked, r.last);
    endfunction

    task automatic forecast_rows(input logic [1:0] f_op, input logic [7:0] f_pin,
                                 input logic [1:0] f_mode, input logic f_level,
                                 input logic [31:0] f_time, input logic f_armed);
        irq_row_t rows [$];
        irq_row_t r;
        int       free_slot;
        logic     any_wait;
        free_slot = -1;
        if (f_op == OP_ATTACH && f_mode != MODE_NONE)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (!tbl_used[i] && free_slot < 0)
                    free_slot = i;
            r = '0;
            r.pin = f_pin;
            if (free_slot >= 0)
            begin
                tbl_used[free_slot]  = 1'b1;
                tbl_pin[free_slot]   = f_pin;
                tbl_mode[free_slot]  = f_mode;
                tbl_quota[free_slot] = quota_lim;
                tbl_wait[free_slot]  = 8'd0;
                r.slot = SLOT_OUT_W'(free_slot);
                r.ok   = 1'b1;
            end
            rows.push_back(r);
        end
        else if (f_op == OP_ATTACH)
        begin
            // detach frees every slot of the pin
            for (int i = 0; i < SLOTS; i++)
                if (tbl_used[i] && tbl_pin[i] == f_pin)
                begin
                    tbl_used[i] = 1'b0;
                    r = '0;
                    r.slot = SLOT_OUT_W'(i);
                    r.pin  = f_pin;
                    r.ok   = 1'b1;
                    rows.push_back(r);
                end
            r = '0;
            r.pin = f_pin;
            r.ok  = 1'b1;
            rows.push_back(r);
        end
        else if (f_op == OP_EVENT)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (tbl_used[i] && tbl_pin[i] == f_pin)
                begin
                    r = '0;
                    r.slot = SLOT_OUT_W'(i);
                    r.pin  = f_pin;
                    if (tbl_quota[i] != 16'd0)
                        tbl_quota[i] = tbl_quota[i] - 16'd1;
                    if (tbl_quota[i] != 16'd0)
                    begin
                        r.delivered = 1'b1;
                        r.level     = f_level;
                        r.stamp     = f_time;
                    end
                    rows.push_back(r);
                end
            rows.push_back(irq_row_t'('0));
        end
        else if (f_op == OP_TICK)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (tbl_used[i] && tbl_quota[i] != 16'd0)
                    tbl_quota[i] = quota_lim;
                else if (tbl_used[i])
                begin
                    r = '0;
                    r.slot = SLOT_OUT_W'(i);
                    r.pin  = tbl_pin[i];
                    if (tbl_wait[i] == 8'd0)
                    begin
                        r.flood = 1'b1;
                        r.ierr  = f_armed;
                    end
                    if (f_armed)
                        tbl_wait[i] = 8'd1;
                    else
                    begin
                        if (tbl_wait[i] != WAIT_MAX)
                            tbl_wait[i] = tbl_wait[i] + 8'd1;
                        if (tbl_wait[i] > retry_lim)
                        begin
                            tbl_quota[i] = quota_lim;
                            tbl_wait[i]  = 8'd0;
                            r.retried    = 1'b1;
                        end
                    end
                    rows.push_back(r);
                end
            rows.push_back(irq_row_t'('0));
        end
        else
            rows.push_back(irq_row_t'('0));

        any_wait = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_wait[i] != 8'd0)
                any_wait = 1'b1;
        foreach (rows[k])
        begin
            rows[k].blocked = any_wait;
            rows[k].last    = (k == rows.size() - 1);
            expected_rows.push_back(rows[k]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        irq_row_t got;
        irq_row_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                tbl_used[i]  = 1'b0;
                tbl_pin[i]   = 8'd0;
                tbl_mode[i]  = MODE_NONE;
                tbl_quota[i] = 16'd0;
                tbl_wait[i]  = 8'd0;
            end
            quota_lim = QUOTA_RESET;
            retry_lim = RETRY_RESET;
            expected_rows.delete();
            fail_count   = 0;
            rows_checked = 0;
            reported     = 0;
        end
        else
        begin
            // result beats first: they can only belong to items already taken
            if (out_valid && out_ready)
            begin
                got = '{slot, pin_out, level_out, time_out, delivered, flood_report,
                        armed_flood, retried, ok, flood_blocked, last};
                rows_checked++;
                if (expected_rows.size() == 0)
                begin
                    fail_count++;
                    if (reported < 10)
                        $display("unexpected result beat at %0t: %s", $realtime, row_text(got));
                    reported++;
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (reported < 10)
                        begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected %s", row_text(want));
                            $display("  actual   %s", row_text(got));
                        end
                        reported++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_QUOTA)
                    quota_lim = cfg_data;
                else if (cfg_index == CFG_RETRY)
                    retry_lim = cfg_data[7:0];
            end
            if (in_valid && in_ready)
                forecast_rows(op, pin, edge_mode, level, time_us, armed);
        end
        rows_pending = expected_rows.size();
    end

endmodule

>>> sim/tb.sv
// Top of the flood limiter testbench: clock, reset, item and config stimulus,
// result-side flow control and the verdict.
// Depends on gifl_pkg, gpio_irq_flood_limiter_core and gifl_checker.
module tb;
    import gifl_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] MODE_FALL = 2'd1;
    localparam logic [1:0] MODE_RISE = 2'd2;
    localparam logic [1:0] MODE_BOTH = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            op;
    logic [7:0]            pin;
    logic [1:0]            edge_mode;
    logic                  level;
    logic [31:0]           time_us;
    logic                  armed;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  out_valid;
    logic                  out_ready;
    logic [SLOT_OUT_W-1:0] slot;
    logic [7:0]            pin_out;
    logic                  level_out;
    logic [31:0]           time_out;
    logic                  delivered;
    logic                  flood_report;
    logic                  armed_flood;
    logic                  retried;
    logic                  ok;
    logic                  flood_blocked;
    logic                  last;
    int                    fail_count;
    int                    rows_pending;
    int                    rows_checked;

    bit         steady;        // no idling on either side
    bit         want_backlog;  // asks the result side for its long hold-off
    int         items_by_op [4];
    int         settings_used;
    logic [7:0] pin_pool [6];

    gpio_irq_flood_limiter_core dut (.*);
    gifl_checker                chk (.*);

    always #1 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, one long hold-off to back up the block
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (want_backlog && !hold_done)
            begin
                hold_left = 300;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 20);
        end
    end

    task automatic send_item(input logic [1:0] i_op, input logic [7:0] i_pin,
                             input logic [1:0] i_mode, input logic i_level,
                             input logic [31:0] i_time, input logic i_armed);
        while (!steady && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= i_op;
        pin       <= i_pin;
        edge_mode <= i_mode;
        level     <= i_level;
        time_us   <= i_time;
        armed     <= i_armed;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_by_op[i_op]++;
    endtask

    // wait until every predicted beat is out, then let the block go quiet
    task automatic settle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0 && guard < 50000)
        begin
            guard++;
            @(posedge clk);
        end
        repeat (2 * SLOTS + 4) @(posedge clk);
    endtask

    task automatic reprogram(input logic [15:0] quota, input logic [7:0] retry);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_QUOTA;
        cfg_data  <= quota;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_RETRY;
        cfg_data  <= {8'h00, retry};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic random_item();
        int         pick;
        logic [7:0] p;
        pick = $urandom_range(99);
        p = ($urandom_range(99) < 80) ? pin_pool[$urandom_range(5)] : 8'($urandom);
        if (pick < 22)
            send_item(OP_ATTACH, p, 2'($urandom_range(3, 1)), 1'($urandom), $urandom,
                      1'($urandom));
        else if (pick < 32)
            send_item(OP_ATTACH, p, MODE_NONE, 1'($urandom), $urandom, 1'($urandom));
        else if (pick < 72)
            send_item(OP_EVENT, p, 2'($urandom), 1'($urandom), $urandom, 1'($urandom));
        else if (pick < 94)
            send_item(OP_TICK, p, 2'($urandom), 1'($urandom), $urandom,
                      $urandom_range(99) < 30);
        else
            send_item(OP_UNUSED, p, 2'($urandom), 1'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic run_phase(input logic [15:0] quota, input logic [7:0] retry,
                             input int count, input bit backlog);
        reprogram(quota, retry);
        foreach (pin_pool[k])
            pin_pool[k] = 8'($urandom);
        if (backlog)
            want_backlog = 1;
        repeat (count) random_item();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        op        <= OP_ATTACH;
        pin       <= 8'd0;
        edge_mode <= MODE_NONE;
        level     <= 1'b0;
        time_us   <= 32'd0;
        armed     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_QUOTA;
        cfg_data  <= '0;
        steady        = 0;
        want_backlog  = 0;
        settings_used = 1;
        foreach (items_by_op[k])
            items_by_op[k] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // empty table, unused op, then fill it up
        send_item(OP_EVENT, 8'h00, MODE_NONE, 1'b1, 32'h1234_5678, 1'b0);
        send_item(OP_TICK, 8'h00, MODE_NONE, 1'b0, 32'd0, 1'b1);
        send_item(OP_UNUSED, 8'hFF, MODE_BOTH, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_ATTACH, 8'h00, MODE_FALL, 1'b0, 32'd0, 1'b0);
        send_item(OP_ATTACH, 8'hFF, MODE_BOTH, 1'b0, 32'd0, 1'b0);
        send_item(OP_ATTACH, 8'hA5, MODE_RISE, 1'b0, 32'd0, 1'b0);
        send_item(OP_ATTACH, 8'hA5, MODE_BOTH, 1'b0, 32'd0, 1'b0);
        send_item(OP_ATTACH, 8'h5A, MODE_FALL, 1'b1, 32'd0, 1'b1);
        send_item(OP_ATTACH, 8'h12, MODE_RISE, 1'b0, 32'd0, 1'b0);
        send_item(OP_ATTACH, 8'h34, MODE_BOTH, 1'b0, 32'd0, 1'b0);
        send_item(OP_ATTACH, 8'h56, MODE_FALL, 1'b0, 32'd0, 1'b0);
        // table full
        send_item(OP_ATTACH, 8'h77, MODE_RISE, 1'b0, 32'd0, 1'b0);
        send_item(OP_EVENT, 8'hA5, MODE_NONE, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_EVENT, 8'hFF, MODE_BOTH, 1'b0, 32'd0, 1'b1);
        send_item(OP_TICK, 8'h00, MODE_NONE, 1'b0, 32'd0, 1'b0);
        send_item(OP_ATTACH, 8'hA5, MODE_NONE, 1'b0, 32'd0, 1'b0);
        send_item(OP_ATTACH, 8'h99, MODE_NONE, 1'b0, 32'd0, 1'b0);

        // quota of one: exhaust, flood, retry, armed flood
        reprogram(16'd1, 8'd0);
        send_item(OP_TICK, 8'h00, MODE_NONE, 1'b0, 32'd0, 1'b0);
        send_item(OP_EVENT, 8'h00, MODE_FALL, 1'b1, 32'hDEAD_BEEF, 1'b0);
        send_item(OP_EVENT, 8'h00, MODE_FALL, 1'b1, 32'hCAFE_F00D, 1'b0);
        send_item(OP_TICK, 8'h00, MODE_NONE, 1'b0, 32'd0, 1'b0);
        send_item(OP_EVENT, 8'hFF, MODE_NONE, 1'b0, 32'd5, 1'b0);
        send_item(OP_TICK, 8'h00, MODE_NONE, 1'b0, 32'd0, 1'b1);
        send_item(OP_TICK, 8'h00, MODE_NONE, 1'b0, 32'd0, 1'b1);
        send_item(OP_TICK, 8'h00, MODE_NONE, 1'b0, 32'd0, 1'b0);

        // zero quota: new slots start exhausted; retry limit that never fires
        reprogram(16'd0, 8'd255);
        send_item(OP_ATTACH, 8'h77, MODE_FALL, 1'b0, 32'd0, 1'b0);
        send_item(OP_EVENT, 8'h77, MODE_NONE, 1'b1, 32'h0000_0001, 1'b0);
        send_item(OP_TICK, 8'h00, MODE_NONE, 1'b0, 32'd0, 1'b0);
        send_item(OP_TICK, 8'h00, MODE_NONE, 1'b0, 32'd0, 1'b0);

        run_phase(16'hFFFF, 8'd254, 32, 0);
        steady = 1;
        run_phase(16'd1, 8'd0, 32, 0);
        steady = 0;
        run_phase(16'd0, 8'd255, 32, 0);
        run_phase(16'($urandom_range(5, 2)), 8'($urandom_range(3)), 32, 1);
        run_phase(16'($urandom_range(4, 1)), 8'($urandom_range(6)), 32, 0);
        run_phase(16'($urandom_range(3, 1)), 8'd1, 32, 0);
        run_phase(QUOTA_RESET, RETRY_RESET, 32, 0);
        settle();

        $display("covered %0d attach/detach, %0d events, %0d ticks, %0d unused-op items",
                 items_by_op[OP_ATTACH], items_by_op[OP_EVENT], items_by_op[OP_TICK],
                 items_by_op[OP_UNUSED]);
        $display("%0d result beats checked across %0d limit settings",
                 rows_checked, settings_used);
        if (fail_count == 0 && rows_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> gpio_irq_flood_limiter_core.f
rtl/core/gifl_pkg.sv
rtl/core/gifl_ctrl.sv
rtl/core/gifl_dp.sv
rtl/core/gpio_irq_flood_limiter_core.sv
sim/gifl_checker.sv
sim/tb.sv
